/* src/kdr_pkg.sv */
package kdr_pkg;

  localparam int KEY_COUNT_DEF = 5;
  localparam int INT_W         = 8;
  localparam int CNT_W         = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [INT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE_MASK   = 3'd5;

  // limits shared by every key
  typedef struct packed {
    logic [INT_W-1:0] debounce_limit;
    logic [CNT_W-1:0] first_repeat_delay;
    logic [CNT_W-1:0] repeat_period;
    logic [CNT_W-1:0] long_delay;
  } key_cfg_t;

  // per-key tick controls
  typedef struct packed {
    logic step;
    logic raw;
    logic lock_write;
    logic lock_value;
    logic repeat_en;
    logic long_en;
  } key_ctl_t;

  // per-key results of the tick being processed
  typedef struct packed {
    logic press;
    logic long_ev;
    logic level;
  } key_res_t;

endpackage

/* src/kdr_if.sv */
interface kdr_in_if #(
  parameter int KEY_COUNT = kdr_pkg::KEY_COUNT_DEF
);
  logic                 valid;
  logic                 ready;
  logic [KEY_COUNT-1:0] raw_keys;
  logic                 lock_write;
  logic [KEY_COUNT-1:0] lock_value;

  modport source (output valid, output raw_keys, output lock_write, output lock_value,
                  input ready);
  modport sink   (input valid, input raw_keys, input lock_write, input lock_value,
                  output ready);
endinterface

interface kdr_out_if #(
  parameter int KEY_COUNT = kdr_pkg::KEY_COUNT_DEF
);
  logic                 valid;
  logic                 ready;
  logic [KEY_COUNT-1:0] press_events;
  logic [KEY_COUNT-1:0] long_events;
  logic [KEY_COUNT-1:0] any_events;
  logic [KEY_COUNT-1:0] stable_levels;

  modport source (output valid, output press_events, output long_events,
                  output any_events, output stable_levels, input ready);
  modport sink   (input valid, input press_events, input long_events,
                  input any_events, input stable_levels, output ready);
endinterface

/* src/key_debounce_repeat_long_press_core.sv */
// pipeline: input register, combinational per-key logic, output register
// throughput: one scan tick per cycle while the output register is free or being drained
// backpressure: the input register holds while the output register is full and not taken
// reset (rst_n, synchronous): integrators, counters, flags and locks clear, debounce
// limit returns to 8 and other config registers to 0; both pipeline stages come up empty
module key_debounce_repeat_long_press_core #(
  parameter  int KEY_COUNT = kdr_pkg::KEY_COUNT_DEF,
  localparam int CfgW      = (KEY_COUNT > kdr_pkg::CNT_W) ? KEY_COUNT : kdr_pkg::CNT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kdr_in_if.sink                        in_ch,
  kdr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [kdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CfgW-1:0]               cfg_wdata
);

  // configuration registers
  logic [kdr_pkg::INT_W-1:0] debounce_limit_r;
  logic [kdr_pkg::CNT_W-1:0] first_repeat_delay_r;
  logic [kdr_pkg::CNT_W-1:0] repeat_period_r;
  logic [KEY_COUNT-1:0]      repeat_enable_mask_r;
  logic [kdr_pkg::CNT_W-1:0] long_delay_r;
  logic [KEY_COUNT-1:0]      long_enable_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_limit_r     <= kdr_pkg::DEBOUNCE_LIMIT_RST;
      first_repeat_delay_r <= '0;
      repeat_period_r      <= '0;
      repeat_enable_mask_r <= '0;
      long_delay_r         <= '0;
      long_enable_mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdr_pkg::REG_DEBOUNCE_LIMIT:
          debounce_limit_r <= cfg_wdata[kdr_pkg::INT_W-1:0];
        kdr_pkg::REG_FIRST_REPEAT_DELAY:
          first_repeat_delay_r <= cfg_wdata[kdr_pkg::CNT_W-1:0];
        kdr_pkg::REG_REPEAT_PERIOD:
          repeat_period_r <= cfg_wdata[kdr_pkg::CNT_W-1:0];
        kdr_pkg::REG_REPEAT_ENABLE_MASK:
          repeat_enable_mask_r <= cfg_wdata[KEY_COUNT-1:0];
        kdr_pkg::REG_LONG_DELAY:
          long_delay_r <= cfg_wdata[kdr_pkg::CNT_W-1:0];
        kdr_pkg::REG_LONG_ENABLE_MASK:
          long_enable_mask_r <= cfg_wdata[KEY_COUNT-1:0];
        default: ; // indexes past the map are dropped
      endcase
    end
  end

  // input register stage
  logic                 in_valid_r;
  logic [KEY_COUNT-1:0] raw_r;
  logic                 lock_write_r;
  logic [KEY_COUNT-1:0] lock_value_r;

  // output register stage
  logic                 out_valid_r;
  logic [KEY_COUNT-1:0] press_r;
  logic [KEY_COUNT-1:0] long_r;
  logic [KEY_COUNT-1:0] level_r;

  // a tick is processed when the output register is free or being drained
  logic step;
  assign step = in_valid_r && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // payload capture on every input transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r        <= in_ch.raw_keys;
      lock_write_r <= in_ch.lock_write;
      lock_value_r <= in_ch.lock_value;
    end
  end

  // per-key debounce, lock, repeat and long-press logic
  kdr_pkg::key_cfg_t key_cfg;
  kdr_pkg::key_ctl_t key_ctl [KEY_COUNT];
  kdr_pkg::key_res_t key_res [KEY_COUNT];
  logic [KEY_COUNT-1:0] press_nxt;
  logic [KEY_COUNT-1:0] long_nxt;
  logic [KEY_COUNT-1:0] level_nxt;

  assign key_cfg.debounce_limit     = debounce_limit_r;
  assign key_cfg.first_repeat_delay = first_repeat_delay_r;
  assign key_cfg.repeat_period      = repeat_period_r;
  assign key_cfg.long_delay         = long_delay_r;

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    assign key_ctl[k].step       = step;
    assign key_ctl[k].raw        = raw_r[k];
    assign key_ctl[k].lock_write = lock_write_r;
    assign key_ctl[k].lock_value = lock_value_r[k];
    assign key_ctl[k].repeat_en  = repeat_enable_mask_r[k];
    assign key_ctl[k].long_en    = long_enable_mask_r[k];

    kdr_key u_key (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (key_cfg),
      .ctl   (key_ctl[k]),
      .res   (key_res[k])
    );

    assign press_nxt[k] = key_res[k].press;
    assign long_nxt[k]  = key_res[k].long_ev;
    assign level_nxt[k] = key_res[k].level;
  end

  // result register: fills on a processed tick, empties on an output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      press_r <= press_nxt;
      long_r  <= long_nxt;
      level_r <= level_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.press_events  = press_r;
  assign out_ch.long_events   = long_r;
  assign out_ch.any_events    = press_r | long_r;
  assign out_ch.stable_levels = level_r;

endmodule

/* src/kdr_key.sv */
module kdr_key (
  input  logic              clk,
  input  logic              rst_n,
  input  kdr_pkg::key_cfg_t cfg,
  input  kdr_pkg::key_ctl_t ctl,
  output kdr_pkg::key_res_t res
);

  logic [kdr_pkg::INT_W-1:0] integ_r, integ_nxt;
  logic [kdr_pkg::CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [kdr_pkg::CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic [kdr_pkg::CNT_W-1:0] long_cnt_r, long_cnt_nxt;
  logic deb_r, deb_nxt;
  logic prev_r, prev_nxt;
  logic lock_r, lock_nxt;
  logic long_flag_r, long_flag_nxt;
  logic long_fired_r, long_fired_nxt;
  logic press;

  always_comb begin
    integ_nxt      = integ_r;
    deb_nxt        = deb_r;
    first_cnt_nxt  = first_cnt_r;
    rep_cnt_nxt    = rep_cnt_r;
    long_cnt_nxt   = long_cnt_r;
    long_flag_nxt  = long_flag_r;
    long_fired_nxt = long_fired_r;
    lock_nxt       = ctl.lock_write ? ctl.lock_value : lock_r;
    press          = 1'b0;

    // saturating integrator, level moves only at a bound
    if (ctl.raw) begin
      if (integ_r < cfg.debounce_limit) integ_nxt = integ_r + 1'b1;
      else deb_nxt = 1'b1;
    end else begin
      if (integ_r != '0) integ_nxt = integ_r - 1'b1;
      else deb_nxt = 1'b0;
    end

    if (!deb_nxt) lock_nxt = 1'b0;

    if (lock_nxt) begin
      long_flag_nxt = 1'b0;
    end else begin
      press = deb_nxt & ~prev_r;

      if (ctl.repeat_en) begin
        if (deb_nxt) begin
          if (first_cnt_r < cfg.first_repeat_delay) begin
            first_cnt_nxt = first_cnt_r + 1'b1;
          end else if (rep_cnt_r < cfg.repeat_period) begin
            rep_cnt_nxt = rep_cnt_r + 1'b1;
          end else begin
            press       = 1'b1;
            rep_cnt_nxt = '0;
          end
        end else begin
          first_cnt_nxt = '0;
          rep_cnt_nxt   = '0;
        end
      end

      if (ctl.long_en) begin
        if (deb_nxt) begin
          if (long_cnt_r < cfg.long_delay) begin
            long_cnt_nxt = long_cnt_r + 1'b1;
          end else if (!long_fired_r) begin
            long_flag_nxt  = 1'b1;
            long_fired_nxt = 1'b1;
          end else begin
            long_flag_nxt = 1'b0;
          end
        end else begin
          long_flag_nxt  = 1'b0;
          long_fired_nxt = 1'b0;
          long_cnt_nxt   = '0;
        end
      end
    end

    prev_nxt = deb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      first_cnt_r  <= '0;
      rep_cnt_r    <= '0;
      long_cnt_r   <= '0;
      deb_r        <= 1'b0;
      prev_r       <= 1'b0;
      lock_r       <= 1'b0;
      long_flag_r  <= 1'b0;
      long_fired_r <= 1'b0;
    end else if (ctl.step) begin
      integ_r      <= integ_nxt;
      first_cnt_r  <= first_cnt_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      long_cnt_r   <= long_cnt_nxt;
      deb_r        <= deb_nxt;
      prev_r       <= prev_nxt;
      lock_r       <= lock_nxt;
      long_flag_r  <= long_flag_nxt;
      long_fired_r <= long_fired_nxt;
    end
  end

  assign res.press   = press;
  assign res.long_ev = long_flag_nxt;
  assign res.level   = deb_nxt;

endmodule
